### hw/rtl/bgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bgc_pkg
// Shared types, event codes and constants of the button gesture classifier.
// ---------------------------------------------------------------------------
package bgc_pkg;

	localparam int NUM_BTN       = 3;
	localparam int SELECT_IDX    = 2;
	localparam int TIME_BITS_DEF = 32;
	localparam int QUEUE_DEPTH   = 2;

	// Bit positions in the per-button fired flags
	localparam int FLG_SHORT  = 0;
	localparam int FLG_LONG   = 1;
	localparam int FLG_VLONG  = 2;
	localparam int FLG_REPEAT = 3;
	localparam int FLG_W      = 4;

	typedef enum logic [3:0] {
		EV_UP_SHORT   = 4'd0,
		EV_UP_LONG    = 4'd1,
		EV_UP_HELD    = 4'd2,
		EV_DOWN_SHORT = 4'd3,
		EV_DOWN_LONG  = 4'd4,
		EV_DOWN_HELD  = 4'd5,
		EV_SEL_SHORT  = 4'd6,
		EV_SEL_LONG   = 4'd7,
		EV_SEL_VLONG  = 4'd8
	} ev_code_t;

	localparam ev_code_t CODE_SHORT [NUM_BTN] = '{EV_UP_SHORT, EV_DOWN_SHORT, EV_SEL_SHORT};
	localparam ev_code_t CODE_LONG  [NUM_BTN] = '{EV_UP_LONG, EV_DOWN_LONG, EV_SEL_LONG};
	// Select never repeats; its entry is never emitted
	localparam ev_code_t CODE_HELD  [NUM_BTN] = '{EV_UP_HELD, EV_DOWN_HELD, EV_SEL_LONG};

	typedef enum logic [2:0] {
		REG_ACTIVE_LOW      = 3'd0,
		REG_DEBOUNCE        = 3'd1,
		REG_LONG            = 3'd2,
		REG_VERY_LONG       = 3'd3,
		REG_REPEAT_DELAY    = 3'd4,
		REG_REPEAT_INTERVAL = 3'd5
	} reg_idx_t;

	localparam logic        RST_ACTIVE_LOW      = 1'b1;
	localparam logic [15:0] RST_DEBOUNCE        = 16'd50;
	localparam logic [15:0] RST_LONG            = 16'd1000;
	localparam logic [15:0] RST_VERY_LONG       = 16'd3000;
	localparam logic [15:0] RST_REPEAT_DELAY    = 16'd1500;
	localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd150;

	typedef struct packed {
		logic        active_low;
		logic [15:0] debounce_ms;
		logic [15:0] long_ms;
		logic [15:0] very_long_ms;
		logic [15:0] repeat_delay_ms;
		logic [15:0] repeat_interval_ms;
	} cfg_t;

	// Events caused by one poll: one slot per button, in output order
	typedef struct packed {
		logic [NUM_BTN-1:0]           mask;
		ev_code_t [NUM_BTN-1:0]       code;
	} poll_rec_t;

endpackage
`default_nettype wire

### hw/rtl/bgc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bgc_front
// Debounces the three buttons, tracks presses, classifies gestures; one poll
// per cycle unless the queue is full, a poll's events pushed as one record.
// ---------------------------------------------------------------------------
module bgc_front
	import bgc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [31:0]        now_ms,
	input  wire logic [NUM_BTN-1:0] lvl,
	input  wire logic               q_full,
	output logic                    push,
	output poll_rec_t               rec
);

	logic                 accept;
	logic [TIME_BITS-1:0] now_t;
	logic [NUM_BTN-1:0]   fire;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign now_t    = now_ms[TIME_BITS-1:0];
	assign rec.mask = fire;
	assign push     = accept & (|fire);

	for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
		logic                 last_raw_q;
		logic [TIME_BITS-1:0] db_start_q;
		logic                 stable_q;
		logic [TIME_BITS-1:0] press_start_q;
		logic [TIME_BITS-1:0] rep_time_q;
		logic [FLG_W-1:0]     flags_q;

		logic                 raw;
		logic [TIME_BITS-1:0] db_start_n;
		logic                 settled;
		logic                 new_press;
		logic [TIME_BITS-1:0] pstart_n;
		logic [TIME_BITS-1:0] held;
		logic [FLG_W-1:0]     f;
		logic [FLG_W-1:0]     flags_n;
		logic [TIME_BITS-1:0] rt;
		logic                 rep_on;
		logic                 ev;
		ev_code_t             code;

		// Classify this button for the current poll
		always_comb begin
			raw        = cfg.active_low ? ~lvl[b] : lvl[b];
			db_start_n = (raw != last_raw_q) ? now_t : db_start_q;
			settled    = (now_t - db_start_n) >= TIME_BITS'(cfg.debounce_ms);
			new_press  = raw & ~stable_q;
			pstart_n   = new_press ? now_t : press_start_q;
			held       = now_t - pstart_n;
			f          = new_press ? '0 : flags_q;
			rt         = new_press ? now_t : rep_time_q;
			flags_n    = f;
			rep_on     = 1'b0;
			ev         = 1'b0;
			code       = CODE_SHORT[b];
			if (raw) begin
				if (!f[FLG_VLONG] && held >= TIME_BITS'(cfg.very_long_ms)) begin
					flags_n[FLG_VLONG] = 1'b1;
					flags_n[FLG_LONG]  = 1'b1;
					flags_n[FLG_SHORT] = 1'b1;
					ev                 = (b == SELECT_IDX);
					code               = EV_SEL_VLONG;
				end else if (!f[FLG_LONG] && held >= TIME_BITS'(cfg.long_ms)) begin
					flags_n[FLG_LONG]  = 1'b1;
					flags_n[FLG_SHORT] = 1'b1;
					ev                 = 1'b1;
					code               = CODE_LONG[b];
				end else if (f[FLG_LONG] && b != SELECT_IDX) begin
					rep_on = f[FLG_REPEAT] | (held >= TIME_BITS'(cfg.repeat_delay_ms));
					// Repeat starts now: restart the interval from this poll
					if (!f[FLG_REPEAT] && rep_on) begin
						rt = now_t;
					end
					flags_n[FLG_REPEAT] = rep_on;
					if (rep_on && (now_t - rt) >= TIME_BITS'(cfg.repeat_interval_ms)) begin
						rt   = now_t;
						ev   = 1'b1;
						code = CODE_HELD[b];
					end
				end
			end else if (stable_q) begin
				// Release: short only if nothing fired and held below long
				if (!flags_q[FLG_SHORT] && held < TIME_BITS'(cfg.long_ms)) begin
					ev   = 1'b1;
					code = CODE_SHORT[b];
				end
			end
		end

		assign fire[b]     = ev & settled;
		assign rec.code[b] = code;

		// Commit state on an accepted poll; hold while bouncing
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				last_raw_q    <= 1'b0;
				db_start_q    <= '0;
				stable_q      <= 1'b0;
				press_start_q <= '0;
				rep_time_q    <= '0;
				flags_q       <= '0;
			end else if (accept) begin
				last_raw_q <= raw;
				db_start_q <= db_start_n;
				if (settled) begin
					stable_q      <= raw;
					press_start_q <= pstart_n;
					rep_time_q    <= rt;
					flags_q       <= flags_n;
				end
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bgc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bgc_queue
// Short FIFO of per-poll event records between classifier and output.
// ---------------------------------------------------------------------------
module bgc_queue
	import bgc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire poll_rec_t wr_rec,
	output logic           full,
	input  wire logic      pop,
	output logic           rd_valid,
	output poll_rec_t      rd_rec
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	poll_rec_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_rec   = mem_q[rd_ptr_q];
	assign do_push  = push & ~full;
	assign do_pop   = pop & rd_valid;

	// Store the pushed record
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bgc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bgc_back
// Serializes each poll record into event words, one per cycle unless the
// output stalls, in button order, marking the last word of the poll.
// ---------------------------------------------------------------------------
module bgc_back
	import bgc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_valid,
	input  wire poll_rec_t q_rec,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_stall,
	output logic [3:0]     event_code,
	output logic           last_of_poll
);

	logic [NUM_BTN-1:0]     pend_mask_q;
	ev_code_t [NUM_BTN-1:0] pend_code_q;
	logic                   out_valid_q;
	ev_code_t               code_q;
	logic                   last_q;

	logic                   slot_free;
	logic [NUM_BTN-1:0]     cur_mask;
	ev_code_t [NUM_BTN-1:0] cur_code;
	logic [NUM_BTN-1:0]     pick;
	logic [NUM_BTN-1:0]     rest;
	ev_code_t               pick_code;
	logic                   emit;

	assign slot_free = ~out_valid_q | ~out_stall;

	// Pick the lowest pending button, from the held record or the queue head
	always_comb begin
		if (pend_mask_q != '0) begin
			cur_mask = pend_mask_q;
			cur_code = pend_code_q;
		end else begin
			cur_mask = q_valid ? q_rec.mask : '0;
			cur_code = q_rec.code;
		end
		pick      = cur_mask & (~cur_mask + 1'b1);
		rest      = cur_mask & ~pick;
		pick_code = cur_code[0];
		for (int i = 0; i < NUM_BTN; i++) begin
			if (pick[i]) begin
				pick_code = cur_code[i];
			end
		end
		emit = slot_free & (cur_mask != '0);
		pop  = emit & (pend_mask_q == '0);
	end

	// Track the remainder of the current poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				pend_mask_q <= rest;
			end
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (emit) begin
			pend_code_q <= cur_code;
			code_q      <= pick_code;
			last_q      <= (rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign event_code   = code_q;
	assign last_of_poll = last_q;

endmodule
`default_nettype wire

### hw/rtl/button_gesture_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Each poll record is queued, then its words go to the output word register.
// Throughput: one poll per cycle into the classifier while the queue has room;
// the output sends one event word per cycle unless stalled, 1 to 3 per poll.
// A two-record queue between classifier and output absorbs bursts and stalls.
// Reset: button state, queue and output are cleared; registers take defaults.
// ---------------------------------------------------------------------------
// button_gesture_classifier_unit
// Debounced three-button gesture classifier with APB-style register port.
// ---------------------------------------------------------------------------
module button_gesture_classifier_unit
	import bgc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic        up_level,
	input  wire logic        down_level,
	input  wire logic        select_level,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       event_code,
	output logic             last_of_poll,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t      cfg_q;
	reg_idx_t  widx;
	logic      wr_en;
	logic      push;
	logic      q_full;
	poll_rec_t push_rec;
	logic      pop;
	logic      q_valid;
	poll_rec_t q_rec;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low         <= RST_ACTIVE_LOW;
			cfg_q.debounce_ms        <= RST_DEBOUNCE;
			cfg_q.long_ms            <= RST_LONG;
			cfg_q.very_long_ms       <= RST_VERY_LONG;
			cfg_q.repeat_delay_ms    <= RST_REPEAT_DELAY;
			cfg_q.repeat_interval_ms <= RST_REPEAT_INTERVAL;
		end else if (wr_en) begin
			case (widx)
				REG_ACTIVE_LOW:      cfg_q.active_low         <= pwdata[0];
				REG_DEBOUNCE:        cfg_q.debounce_ms        <= pwdata[15:0];
				REG_LONG:            cfg_q.long_ms            <= pwdata[15:0];
				REG_VERY_LONG:       cfg_q.very_long_ms       <= pwdata[15:0];
				REG_REPEAT_DELAY:    cfg_q.repeat_delay_ms    <= pwdata[15:0];
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval_ms <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (widx)
			REG_ACTIVE_LOW:      prdata = {31'd0, cfg_q.active_low};
			REG_DEBOUNCE:        prdata = {16'd0, cfg_q.debounce_ms};
			REG_LONG:            prdata = {16'd0, cfg_q.long_ms};
			REG_VERY_LONG:       prdata = {16'd0, cfg_q.very_long_ms};
			REG_REPEAT_DELAY:    prdata = {16'd0, cfg_q.repeat_delay_ms};
			REG_REPEAT_INTERVAL: prdata = {16'd0, cfg_q.repeat_interval_ms};
			default:             prdata = '0;
		endcase
	end

	bgc_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.now_ms   (now_ms),
		.lvl      ({select_level, down_level, up_level}),
		.q_full   (q_full),
		.push     (push),
		.rec      (push_rec)
	);

	bgc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_rec   (push_rec),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_rec   (q_rec)
	);

	bgc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_rec        (q_rec),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.last_of_poll (last_of_poll)
	);

endmodule
`default_nettype wire

### dv/gesture_event_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gesture_event_checker
// Watches the poll, event and register ports of the gesture classifier. It
// keeps its own copy of the registers and of the per-button debounce and
// press state, works out the event words of each accepted poll and compares
// every accepted event word, in order, with the oldest one still waiting.
// ---------------------------------------------------------------------------
module gesture_event_checker
	import bgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic        up_level,
	input  wire logic        down_level,
	input  wire logic        select_level,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [3:0]  event_code,
	input  wire logic        last_of_poll,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               mismatches,
	output int               outstanding
);

	typedef struct {
		ev_code_t code;
		logic     last;
	} gesture_word_t;

	// Event words still owed by the block, oldest first
	gesture_word_t expected_words[$];

	// Register copy
	logic        active_low_q;
	logic [15:0] debounce_q;
	logic [15:0] long_q;
	logic [15:0] very_long_q;
	logic [15:0] repeat_delay_q;
	logic [15:0] repeat_interval_q;

	// Per-button debounce and press tracking
	logic             raw_q     [NUM_BTN];
	logic [31:0]      settle_t  [NUM_BTN];
	logic             pressed_q [NUM_BTN];
	logic [31:0]      press_t   [NUM_BTN];
	logic [31:0]      repeat_t  [NUM_BTN];
	logic [FLG_W-1:0] fired_q   [NUM_BTN];

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Advance every button by one poll and queue the words it causes
	task automatic classify_poll(input logic [31:0] now, input logic [NUM_BTN-1:0] lv);
		ev_code_t      fired_codes[$];
		gesture_word_t word;
		logic          pressed;
		logic          was;
		logic [31:0]   held;
		logic [31:0]   gap;
		for (int b = 0; b < NUM_BTN; b++) begin
			pressed = active_low_q ? !lv[b] : lv[b];
			// restart the settle window on any raw change
			if (pressed != raw_q[b]) begin
				settle_t[b] = now;
				raw_q[b] = pressed;
			end
			gap = now - settle_t[b];
			if (gap < {16'd0, debounce_q})
				continue;
			was = pressed_q[b];
			pressed_q[b] = pressed;
			if (pressed && !was) begin
				press_t[b] = now;
				repeat_t[b] = now;
				fired_q[b] = '0;
			end
			held = now - press_t[b];
			if (pressed) begin
				if (!fired_q[b][FLG_VLONG] && held >= {16'd0, very_long_q}) begin
					// very long swallows long and short; only select reports it
					fired_q[b][FLG_VLONG] = 1'b1;
					fired_q[b][FLG_LONG] = 1'b1;
					fired_q[b][FLG_SHORT] = 1'b1;
					if (b == SELECT_IDX)
						fired_codes.push_back(EV_SEL_VLONG);
				end else if (!fired_q[b][FLG_LONG] && held >= {16'd0, long_q}) begin
					fired_q[b][FLG_LONG] = 1'b1;
					fired_q[b][FLG_SHORT] = 1'b1;
					fired_codes.push_back(CODE_LONG[b]);
				end else if (fired_q[b][FLG_LONG] && b != SELECT_IDX) begin
					// arm auto-repeat, then emit at the interval
					if (!fired_q[b][FLG_REPEAT] && held >= {16'd0, repeat_delay_q}) begin
						fired_q[b][FLG_REPEAT] = 1'b1;
						repeat_t[b] = now;
					end
					gap = now - repeat_t[b];
					if (fired_q[b][FLG_REPEAT] && gap >= {16'd0, repeat_interval_q}) begin
						repeat_t[b] = now;
						fired_codes.push_back(CODE_HELD[b]);
					end
				end
			end else if (was) begin
				if (!fired_q[b][FLG_SHORT] && held < {16'd0, long_q})
					fired_codes.push_back(CODE_SHORT[b]);
			end
		end
		foreach (fired_codes[i]) begin
			word.code = fired_codes[i];
			word.last = (i == fired_codes.size() - 1);
			expected_words.push_back(word);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gesture_word_t head;
		if (!arst_n) begin
			expected_words.delete();
			active_low_q = RST_ACTIVE_LOW;
			debounce_q = RST_DEBOUNCE;
			long_q = RST_LONG;
			very_long_q = RST_VERY_LONG;
			repeat_delay_q = RST_REPEAT_DELAY;
			repeat_interval_q = RST_REPEAT_INTERVAL;
			for (int b = 0; b < NUM_BTN; b++) begin
				raw_q[b] = 1'b0;
				settle_t[b] = '0;
				pressed_q[b] = 1'b0;
				press_t[b] = '0;
				repeat_t[b] = '0;
				fired_q[b] = '0;
			end
			mismatches = 0;
			outstanding = 0;
		end else begin
			// track register writes; unknown indexes are dropped
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ACTIVE_LOW:      active_low_q = pwdata[0];
					REG_DEBOUNCE:        debounce_q = pwdata[15:0];
					REG_LONG:            long_q = pwdata[15:0];
					REG_VERY_LONG:       very_long_q = pwdata[15:0];
					REG_REPEAT_DELAY:    repeat_delay_q = pwdata[15:0];
					REG_REPEAT_INTERVAL: repeat_interval_q = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				classify_poll(now_ms, {select_level, down_level, up_level});
			// compare each accepted event word with the oldest one owed
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected event word, code %0d", event_code));
				end else begin
					head = expected_words.pop_front();
					if (event_code !== head.code)
						report_mismatch($sformatf("event_code %0d, predicted %0d",
							event_code, head.code));
					if (last_of_poll !== head.last)
						report_mismatch($sformatf("last_of_poll %b, predicted %b, code %0d",
							last_of_poll, head.last, head.code));
				end
			end
			outstanding = expected_words.size();
		end
	end

endmodule

### dv/button_gesture_classifier_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// button_gesture_classifier_unit_test
// Drives polls of three buttons into the gesture classifier: a directed
// walk through short, long, held and very long presses, then phases of
// scripted press timelines with random content and some noise, each under
// its own register setting and pacing. The checker beside the block judges
// every event word; this module builds stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module button_gesture_classifier_unit_test;
	import bgc_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PHASE_POLLS     = 40;
	localparam int NUM_PHASES      = 8;
	localparam int PRESSURE_PHASE  = 3;
	localparam int PAUSE_PHASE     = 7;
	localparam logic [2:0] SPARE_IDX_LO = 3'd6;
	localparam logic [2:0] SPARE_IDX_HI = 3'd7;

	typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [31:0] now_ms = '0;
	logic        up_level = 1'b1;
	logic        down_level = 1'b1;
	logic        select_level = 1'b1;
	logic        out_stall = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic        in_stall;
	wire logic        out_valid;
	wire logic [3:0]  event_code;
	wire logic        last_of_poll;
	wire logic [31:0] prdata;
	wire logic        pready;
	int mismatches;
	int outstanding;

	// Stimulus state
	logic [31:0]        clock_ms = '0;
	logic [NUM_BTN-1:0] pins = '1;
	logic [31:0]        toggle_at [NUM_BTN];
	int cfg_deb, cfg_long, cfg_vlong, cfg_delay, cfg_ivl;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int step_max = 1;
	int polls_sent = 0;
	int words_seen = 0;
	int settings_done = 0;
	int quiet_cycles = 0;

	// Long receiver hold-off, requested by toggling
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int   hold_left = 0;

	button_gesture_classifier_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.now_ms(now_ms), .up_level(up_level), .down_level(down_level),
		.select_level(select_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_code(event_code), .last_of_poll(last_of_poll),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gesture_event_checker event_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.now_ms(now_ms), .up_level(up_level), .down_level(down_level),
		.select_level(select_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_code(event_code), .last_of_poll(last_of_poll),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: count cycles in which no word moves on any port
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (out_valid && !out_stall)
			words_seen <= words_seen + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one poll word, levels as {select, down, up}; hold until accepted
	task automatic send_poll(input logic [31:0] t, input logic [NUM_BTN-1:0] lv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		up_level <= lv[0];
		down_level <= lv[1];
		select_level <= lv[2];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		polls_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every owed word is out and the pipe is empty
	task automatic drain_block();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Write all six registers; upper carries junk for the unused data bits
	task automatic apply_settings(input logic al, input logic [15:0] deb,
			input logic [15:0] lng, input logic [15:0] vl, input logic [15:0] dly,
			input logic [15:0] ivl, input logic [15:0] upper);
		write_reg(REG_ACTIVE_LOW, {upper, upper[14:0], al});
		write_reg(REG_DEBOUNCE, {upper, deb});
		write_reg(REG_LONG, {upper, lng});
		write_reg(REG_VERY_LONG, {upper, vl});
		write_reg(REG_REPEAT_DELAY, {upper, dly});
		write_reg(REG_REPEAT_INTERVAL, {upper, ivl});
		cfg_deb = int'(deb);
		cfg_long = int'(lng);
		cfg_vlong = int'(vl);
		cfg_delay = int'(dly);
		cfg_ivl = int'(ivl);
		settings_done++;
	endtask

	task automatic set_pace(input pace_t mode);
		case (mode)
			PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			PACE_SEND_IDLE:  begin send_idle_pct = 48; recv_stall_pct = 0;  end
			PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 48; end
			default:         begin send_idle_pct = 13; recv_stall_pct = 13; end
		endcase
	endtask

	// Length of the next level segment: glitch, short, long or very long hold
	function automatic int pick_hold();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom_range(0, cfg_deb);
			2, 3, 4: return cfg_deb + $urandom_range(0, cfg_long);
			5, 6:    return cfg_deb + cfg_long + $urandom_range(0, cfg_vlong);
			default: return cfg_deb + cfg_vlong + cfg_delay + $urandom_range(0, 6 * cfg_ivl + 10);
		endcase
	endfunction

	// Advance the press timelines by one poll; now and then jump at random
	task automatic gesture_poll();
		if ($urandom_range(0, 99) < 12) begin
			clock_ms = $urandom();
			pins = NUM_BTN'($urandom_range(0, 7));
			for (int b = 0; b < NUM_BTN; b++)
				toggle_at[b] = clock_ms + pick_hold();
		end else begin
			clock_ms = clock_ms + $urandom_range(0, step_max);
			for (int b = 0; b < NUM_BTN; b++) begin
				if ($signed(clock_ms - toggle_at[b]) >= 0) begin
					pins[b] = ~pins[b];
					toggle_at[b] = clock_ms + pick_hold();
				end
			end
		end
		send_poll(clock_ms, pins);
	endtask

	task automatic run_phase(input int p);
		drain_block();
		clock_ms = $urandom();
		case (p)
			0: begin
				apply_settings(1'b0, 16'd3, 16'd20, 16'd45, 16'd30, 16'd5, 16'h0);
				write_reg(SPARE_IDX_LO, $urandom());
				write_reg(SPARE_IDX_HI, $urandom());
				set_pace(PACE_FREE);
			end
			1: begin
				apply_settings(1'b1, 16'd3, 16'd20, 16'd45, 16'd30, 16'd5, 16'h0);
				set_pace(PACE_SEND_IDLE);
			end
			2: begin
				// start just short of the timestamp wrap
				apply_settings(1'b1, 16'd2, 16'd25, 16'd60, 16'd35, 16'd7, 16'h0);
				set_pace(PACE_RECV_STALL);
				clock_ms = 32'hFFFF_FF00;
			end
			3: begin
				apply_settings(1'b0, 16'd0, 16'd15, 16'd30, 16'd20, 16'd3, 16'h0);
				set_pace(PACE_BOTH);
			end
			4: begin
				apply_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0);
				set_pace(PACE_FREE);
			end
			5: begin
				apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF);
				set_pace(PACE_SEND_IDLE);
			end
			6: begin
				apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
				set_pace(PACE_RECV_STALL);
			end
			default: begin
				apply_settings(1'b1, 16'd5, 16'd30, 16'd70, 16'd40, 16'd6, 16'h0);
				set_pace(PACE_BOTH);
			end
		endcase
		step_max = 1 + (cfg_deb + cfg_long + cfg_vlong + cfg_delay) / 12;
		for (int b = 0; b < NUM_BTN; b++)
			toggle_at[b] = clock_ms + pick_hold();
		for (int i = 0; i < PHASE_POLLS; i++) begin
			// hold the receiver off while polls keep coming
			if (p == PRESSURE_PHASE && i == 10)
				hold_req <= ~hold_req;
			// pause the sender until every owed word is out
			if (p == PAUSE_PHASE && i == 20) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (outstanding != 0)
					@(negedge clk);
			end
			gesture_poll();
		end
	endtask

	initial begin
		for (int b = 0; b < NUM_BTN; b++)
			toggle_at[b] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk under reset settings: low level means pressed
		send_poll(32'd0,    3'b111);
		send_poll(32'd10,   3'b110);  // up goes down, not yet settled
		send_poll(32'd30,   3'b111);  // glitch back: unstable, nothing
		send_poll(32'd100,  3'b111);
		send_poll(32'd200,  3'b110);
		send_poll(32'd260,  3'b110);  // up press accepted
		send_poll(32'd400,  3'b111);
		send_poll(32'd460,  3'b111);  // up short
		send_poll(32'd500,  3'b101);
		send_poll(32'd560,  3'b101);
		send_poll(32'd1600, 3'b101);  // down long
		send_poll(32'd2100, 3'b101);  // repeat armed
		send_poll(32'd2300, 3'b101);  // down held
		send_poll(32'd2400, 3'b101);
		send_poll(32'd2460, 3'b101);  // down held
		send_poll(32'd2500, 3'b111);
		send_poll(32'd2560, 3'b111);  // release after long: no short
		send_poll(32'd3000, 3'b000);
		send_poll(32'd3060, 3'b000);
		send_poll(32'd4100, 3'b000);  // three longs in one poll
		send_poll(32'd6100, 3'b000);  // very long: only select reports
		send_poll(32'd6300, 3'b000);
		send_poll(32'd6500, 3'b000);  // up and down held
		send_poll(32'd6600, 3'b111);
		send_poll(32'd6700, 3'b111);
		send_poll(32'hFFFF_FFFF, 3'b111);

		for (int p = 0; p < NUM_PHASES; p++)
			run_phase(p);

		drain_block();
		repeat (10) @(negedge clk);
		$display("covered %0d polls and %0d event words over %0d register settings",
			polls_sent, words_seen, settings_done);
		$display("pacing ran free, with sender gaps, receiver stalls, a hold-off and a pause");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
